// ===== hw/rtl/mlfr_pkg.sv =====
// Shared types, widths and codes for the MUSCL face reconstruction block.
`default_nettype none

package mlfr_pkg;

  // data format: signed DW-bit values with FB fraction bits
  localparam int DW = 32;
  localparam int FB = 16;

  localparam int DD_W    = DW + 1;        // magnitude of a neighbor difference
  localparam int Q_W     = DW;            // divider quotient / dividend-bit field
  localparam int SM_Q    = DW;            // quotient bits of a smoothness divide
  localparam int PHI_W   = FB + 2;        // limiter value magnitude
  localparam int PHI_Q   = PHI_W;         // quotient bits of a limiter divide
  localparam int DIV_D_W = 2 * DW - 1;    // divisor / remainder width
  localparam int SS_W    = 2 * DW - 1;    // |s|^2
  localparam int M_W     = DD_W + PHI_W;  // |d| * |phi|
  localparam int F_W     = DW + 4;        // face sum before clipping

  localparam int NSIDE  = 2;
  localparam int SIDE_L = 0;
  localparam int SIDE_R = 1;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam int REG_LIMITER_MODE = 0;

  localparam logic signed [DW-1:0] S_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] S_MIN = {1'b1, {(DW-1){1'b0}}};

  typedef enum logic [1:0] {
    LIM_NONE,
    LIM_VAN_ALBADA,
    LIM_VAN_LEER,
    LIM_MINMOD
  } lim_mode_t;

  typedef struct packed {
    logic signed [DW-1:0] far_left_value;
    logic signed [DW-1:0] left_value;
    logic signed [DW-1:0] right_value;
    logic signed [DW-1:0] far_right_value;
  } in_t;

  typedef struct packed {
    logic signed [DW-1:0] left_face_value;
    logic signed [DW-1:0] right_face_value;
    logic                 saturated;
  } out_t;

  // one restoring-divider step: partial remainder, divisor,
  // dividend bits still to shift in (MSB first), quotient so far
  typedef struct packed {
    logic [DIV_D_W-1:0] rem;
    logic [DIV_D_W-1:0] den;
    logic [Q_W-1:0]     dvd;
    logic [Q_W-1:0]     q;
  } div_t;

  // per-side context riding along the pipe
  typedef struct packed {
    logic                 zero_den;
    logic                 num_zero;
    logic                 ovf;
    logic                 qneg;
    logic                 d_neg;
    logic [DD_W-1:0]      d_mag;
    logic signed [DW-1:0] s;
    logic                 byp;
    logic                 phi_neg;
    logic [PHI_W-1:0]     byp_mag;
  } side_t;

  typedef struct packed {
    logic signed [DW-1:0]   lv;
    logic signed [DW-1:0]   rv;
    logic                   sat;
    side_t [NSIDE-1:0]      sd;
  } ctx_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mlfr_div_cell.sv =====
// One registered restoring-division step of the divider chain.
`default_nettype none

module mlfr_div_cell (
  input  logic           clk,
  input  logic           en,
  input  mlfr_pkg::div_t div_i,
  output mlfr_pkg::div_t div_o
);
  import mlfr_pkg::*;

  logic [DIV_D_W:0] trial;
  logic [DIV_D_W:0] diff;
  logic             fits;
  div_t             div_nxt;
  div_t             div_r;

  always_comb begin
    trial       = {div_i.rem, div_i.dvd[Q_W-1]};
    diff        = trial - {1'b0, div_i.den};
    fits        = trial >= {1'b0, div_i.den};
    div_nxt.den = div_i.den;
    div_nxt.dvd = {div_i.dvd[Q_W-2:0], 1'b0};
    div_nxt.q   = {div_i.q[Q_W-2:0], fits};
    div_nxt.rem = fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r <= div_nxt;
    end
  end

  assign div_o = div_r;

endmodule

`default_nettype wire

// ===== hw/rtl/mlfr_smooth_prep.sv =====
// Smoothness operands: (c-b)/(d-c+1), magnitudes, special cases, divider seed.
`default_nettype none

module mlfr_smooth_prep (
  input  logic signed [mlfr_pkg::DW-1:0] b_i,
  input  logic signed [mlfr_pkg::DW-1:0] c_i,
  input  logic signed [mlfr_pkg::DW-1:0] d_i,
  output mlfr_pkg::div_t                 div_o,
  output mlfr_pkg::side_t                side_o
);
  import mlfr_pkg::*;

  localparam int DV_W  = DD_W + FB;
  localparam int CMP_W = DD_W + DW - FB;

  logic signed [DD_W-1:0] num;
  logic signed [DD_W-1:0] dd;
  logic signed [DD_W:0]   den;
  logic [DD_W:0]          den_abs;
  logic [DD_W-1:0]        num_mag;
  logic [DD_W-1:0]        dd_mag;
  logic [DD_W-1:0]        den_mag;
  logic [DV_W-1:0]        dv;

  always_comb begin
    num     = DD_W'(c_i) - DD_W'(b_i);
    dd      = DD_W'(d_i) - DD_W'(c_i);
    den     = (DD_W+1)'(dd) + (DD_W+1)'(1);
    num_mag = num[DD_W-1] ? DD_W'(-num) : DD_W'(num);
    dd_mag  = dd[DD_W-1] ? DD_W'(-dd) : DD_W'(dd);
    den_abs = den[DD_W] ? (DD_W+1)'(-den) : (DD_W+1)'(den);
    den_mag = den_abs[DD_W-1:0];
    dv      = {num_mag, {FB{1'b0}}};

    div_o.rem = DIV_D_W'(dv >> SM_Q);
    div_o.dvd = dv[Q_W-1:0];
    div_o.den = DIV_D_W'(den_mag);
    div_o.q   = '0;

    side_o          = '0;
    side_o.zero_den = (den == '0);
    side_o.num_zero = (num == '0);
    // quotient would need more than Q_W bits
    side_o.ovf      = CMP_W'(num_mag) >= (CMP_W'(den_mag) << (DW - FB));
    side_o.qneg     = num[DD_W-1] ^ den[DD_W];
    side_o.d_neg    = dd[DD_W-1];
    side_o.d_mag    = dd_mag;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mlfr_phi_prep.sv =====
// Limiter operands per mode: divider seed for van Albada and for van Leer with s > 0, bypass otherwise.
`default_nettype none

module mlfr_phi_prep (
  input  mlfr_pkg::lim_mode_t          mode_i,
  input  mlfr_pkg::side_t              side_i,
  input  logic [mlfr_pkg::SS_W-1:0]    ss_i,
  output mlfr_pkg::side_t              side_o,
  output mlfr_pkg::div_t               div_o
);
  import mlfr_pkg::*;

  localparam int N_W = 2 * DW;
  localparam logic [DW-1:0] ONE = DW'(1) << FB;

  logic                  s_neg;
  logic [DW-1:0]         as;
  logic [N_W-1:0]        nv;
  logic [N_W-1:0]        nabs;
  logic                  nneg;
  logic [DIV_D_W-1:0]    nmag;
  logic [DIV_D_W-1:0]    dval;
  logic                  byp;
  logic [PHI_W-1:0]      bmag;
  logic [DIV_D_W+FB-1:0] dv;

  always_comb begin
    s_neg = side_i.s[DW-1];
    as    = s_neg ? DW'(-side_i.s) : DW'(side_i.s);
    nv    = '0;
    nabs  = '0;
    nneg  = 1'b0;
    nmag  = '0;
    dval  = DIV_D_W'(1);
    byp   = 1'b1;
    bmag  = '0;

    unique case (mode_i)
      LIM_NONE: begin
      end
      LIM_VAN_ALBADA: begin
        // (s^2 + s) / (1 + s^2)
        byp  = 1'b0;
        nv   = s_neg ? N_W'(ss_i) - (N_W'(as) << FB) : N_W'(ss_i) + (N_W'(as) << FB);
        nneg = nv[N_W-1];
        nabs = nneg ? -nv : nv;
        nmag = nabs[DIV_D_W-1:0];
        dval = ss_i + (DIV_D_W'(1) << (2 * FB));
      end
      LIM_VAN_LEER: begin
        // 2s / (1 + s) for s > 0
        if (!s_neg && as != '0) begin
          byp  = 1'b0;
          nmag = DIV_D_W'(as) << 1;
          dval = DIV_D_W'(as) + DIV_D_W'(ONE);
        end
      end
      LIM_MINMOD: begin
        if (!s_neg) begin
          bmag = (as > ONE) ? PHI_W'(ONE) : PHI_W'(as);
        end
      end
    endcase

    dv        = {nmag, {FB{1'b0}}};
    div_o.rem = DIV_D_W'(dv >> PHI_Q);
    div_o.dvd = {dv[PHI_Q-1:0], {(Q_W-PHI_Q){1'b0}}};
    div_o.den = dval;
    div_o.q   = '0;

    side_o         = side_i;
    side_o.byp     = byp;
    side_o.byp_mag = bmag;
    side_o.phi_neg = nneg;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/muscl_limited_face_reconstruction.sv =====
// Top level: MUSCL limited face reconstruction pipeline with APB limiter select.
// Usage
//   Input transfer: in_valid/in_ready with in_data = {ll, l, r, rr}, signed
//   Q16.16, one conserved component per transfer. Output transfer:
//   out_valid/out_ready with out_data = {left face, right face, saturated}.
//   Results leave in input order, one per input transfer.
// Throughput
//   One item per cycle sustained while out_ready takes each result.
//   Work is done by chains of one-bit divider cells, per side: 32 cells for the
//   smoothness quotient, 18 cells for the limiter quotient,
//   with a squaring stage between and a multiply stage after.
// Stall behavior
//   The whole pipe moves on one enable. It stops only when the output
//   register holds an untaken result and the last pipe stage holds another;
//   until then items keep entering and every stage, bubbles included, moves on.
// Reset
//   rst_n (synchronous, active low) clears all stage valids, the output
//   valid and limiter_mode (none, first order). No clearing pass.
// Config
//   APB: limiter_mode at byte 0, bits [1:0]. Write only while idle.
`default_nettype none

module muscl_limited_face_reconstruction (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mlfr_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mlfr_pkg::out_t                out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mlfr_pkg::APB_AW-1:0]   paddr,
  input  logic [mlfr_pkg::APB_DW-1:0]   pwdata,
  output logic [mlfr_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import mlfr_pkg::*;

  // ---------------- configuration ----------------
  lim_mode_t limiter_mode_r;
  logic      cfg_wr;
  logic      cfg_sel0;

  assign pready   = 1'b1;
  assign cfg_sel0 = (paddr[APB_AW-1:2] == 1'(REG_LIMITER_MODE));
  assign cfg_wr   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limiter_mode_r <= LIM_NONE;
    end else if (cfg_wr && cfg_sel0) begin
      limiter_mode_r <= lim_mode_t'(pwdata[1:0]);
    end
  end

  assign prdata = cfg_sel0 ? APB_DW'(limiter_mode_r) : '0;

  // ---------------- pipe control ----------------
  logic             en;
  logic [SM_Q-1:0]  vld_sm_r;
  logic             vld_a_r;
  logic             vld_b_r;
  logic [PHI_Q-1:0] vld_phi_r;
  logic             vld_d_r;
  logic             out_valid_r;
  logic             out_valid_nxt;

  // hold only when a finished result is parked and another waits behind it
  assign en       = !(vld_d_r && out_valid_r && !out_ready);
  assign in_ready = en;

  always_comb begin
    if (en && vld_d_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_sm_r    <= '0;
      vld_a_r     <= 1'b0;
      vld_b_r     <= 1'b0;
      vld_phi_r   <= '0;
      vld_d_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (en) begin
        vld_sm_r  <= {vld_sm_r[SM_Q-2:0], in_valid};
        vld_a_r   <= vld_sm_r[SM_Q-1];
        vld_b_r   <= vld_a_r;
        vld_phi_r <= {vld_phi_r[PHI_Q-2:0], vld_b_r};
        vld_d_r   <= vld_phi_r[PHI_Q-1];
      end
    end
  end

  // ---------------- smoothness: prep + divider chain ----------------
  side_t prep_side [NSIDE];
  div_t  sm_div    [NSIDE][SM_Q+1];
  ctx_t  ctx0;
  ctx_t  ctx_sm_r  [SM_Q];

  mlfr_smooth_prep u_prep_l (
    .b_i   (in_data.far_left_value),
    .c_i   (in_data.left_value),
    .d_i   (in_data.right_value),
    .div_o (sm_div[SIDE_L][0]),
    .side_o(prep_side[SIDE_L])
  );

  mlfr_smooth_prep u_prep_r (
    .b_i   (in_data.left_value),
    .c_i   (in_data.right_value),
    .d_i   (in_data.far_right_value),
    .div_o (sm_div[SIDE_R][0]),
    .side_o(prep_side[SIDE_R])
  );

  always_comb begin
    ctx0     = '0;
    ctx0.lv  = in_data.left_value;
    ctx0.rv  = in_data.right_value;
    for (int i = 0; i < NSIDE; i++) begin
      ctx0.sd[i] = prep_side[i];
    end
  end

  for (genvar g = 0; g < NSIDE; g++) begin : g_sm_side
    for (genvar k = 0; k < SM_Q; k++) begin : g_sm_cell
      mlfr_div_cell u_cell (
        .clk  (clk),
        .en   (en),
        .div_i(sm_div[g][k]),
        .div_o(sm_div[g][k+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_sm_r[0] <= ctx0;
      for (int k = 1; k < SM_Q; k++) begin
        ctx_sm_r[k] <= ctx_sm_r[k-1];
      end
    end
  end

  // ---------------- stage A: sign, clip, special cases ----------------
  ctx_t ctxa_nxt;
  ctx_t ctxa_r;

  always_comb begin
    side_t          sc;
    logic [Q_W-1:0] q;
    logic           clip;
    ctxa_nxt = ctx_sm_r[SM_Q-1];
    for (int i = 0; i < NSIDE; i++) begin
      sc   = ctx_sm_r[SM_Q-1].sd[i];
      q    = sm_div[i][SM_Q].q;
      clip = 1'b0;
      priority if (sc.zero_den) begin
        if (sc.num_zero) begin
          ctxa_nxt.sd[i].s = '0;
        end else begin
          clip             = 1'b1;
          ctxa_nxt.sd[i].s = sc.qneg ? S_MIN : S_MAX;
        end
      end else if (sc.ovf) begin
        clip             = 1'b1;
        ctxa_nxt.sd[i].s = sc.qneg ? S_MIN : S_MAX;
      end else if (sc.qneg) begin
        if (q > $unsigned(S_MIN)) begin
          clip             = 1'b1;
          ctxa_nxt.sd[i].s = S_MIN;
        end else begin
          ctxa_nxt.sd[i].s = DW'(-q);
        end
      end else if (q[Q_W-1]) begin
        clip             = 1'b1;
        ctxa_nxt.sd[i].s = S_MAX;
      end else begin
        ctxa_nxt.sd[i].s = DW'(q);
      end
      ctxa_nxt.sat = ctxa_nxt.sat | clip;
    end
  end

  // ---------------- stage B: |s|^2 ----------------
  ctx_t            ctxb_r;
  logic [SS_W-1:0] ss_r [NSIDE];

  always_ff @(posedge clk) begin
    logic [DW-1:0]   as;
    logic [2*DW-1:0] prod;
    if (en) begin
      ctxa_r <= ctxa_nxt;
      ctxb_r <= ctxa_r;
      for (int i = 0; i < NSIDE; i++) begin
        as      = ctxa_r.sd[i].s[DW-1] ? DW'(-ctxa_r.sd[i].s) : DW'(ctxa_r.sd[i].s);
        prod    = as * as;
        ss_r[i] <= prod[SS_W-1:0];
      end
    end
  end

  // ---------------- limiter: prep + divider chain ----------------
  side_t phi_side [NSIDE];
  div_t  phi_div  [NSIDE][PHI_Q+1];
  ctx_t  ctxp0;
  ctx_t  ctx_phi_r [PHI_Q];

  for (genvar g = 0; g < NSIDE; g++) begin : g_phi_side
    mlfr_phi_prep u_phi_prep (
      .mode_i(limiter_mode_r),
      .side_i(ctxb_r.sd[g]),
      .ss_i  (ss_r[g]),
      .side_o(phi_side[g]),
      .div_o (phi_div[g][0])
    );
    for (genvar k = 0; k < PHI_Q; k++) begin : g_phi_cell
      mlfr_div_cell u_cell (
        .clk  (clk),
        .en   (en),
        .div_i(phi_div[g][k]),
        .div_o(phi_div[g][k+1])
      );
    end
  end

  always_comb begin
    ctxp0 = ctxb_r;
    for (int i = 0; i < NSIDE; i++) begin
      ctxp0.sd[i] = phi_side[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_phi_r[0] <= ctxp0;
      for (int k = 1; k < PHI_Q; k++) begin
        ctx_phi_r[k] <= ctx_phi_r[k-1];
      end
    end
  end

  // ---------------- stage D: |d| * |phi| ----------------
  ctx_t           ctxd_r;
  logic [M_W-1:0] m_nxt    [NSIDE];
  logic           cneg_nxt [NSIDE];
  logic [M_W-1:0] m_r      [NSIDE];
  logic           cneg_r   [NSIDE];

  always_comb begin
    side_t            sc;
    logic [PHI_W-1:0] pm;
    for (int i = 0; i < NSIDE; i++) begin
      sc          = ctx_phi_r[PHI_Q-1].sd[i];
      pm          = sc.byp ? sc.byp_mag : phi_div[i][PHI_Q].q[PHI_W-1:0];
      m_nxt[i]    = M_W'(sc.d_mag) * M_W'(pm);
      cneg_nxt[i] = (!sc.byp && sc.phi_neg) ^ sc.d_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctxd_r <= ctx_phi_r[PHI_Q-1];
      for (int i = 0; i < NSIDE; i++) begin
        m_r[i]    <= m_nxt[i];
        cneg_r[i] <= cneg_nxt[i];
      end
    end
  end

  // ---------------- faces, clip, output register ----------------
  out_t out_nxt;
  out_t out_data_r;

  always_comb begin
    logic [M_W-1:0]        c;
    logic signed [F_W-1:0] cs;
    logic signed [F_W-1:0] sum;
    logic signed [DW-1:0]  face [NSIDE];
    logic                  clip;
    clip = ctxd_r.sat;
    for (int i = 0; i < NSIDE; i++) begin
      // phi*d/2 truncated toward zero
      c  = m_r[i] >> (FB + 1);
      cs = cneg_r[i] ? -F_W'(c) : F_W'(c);
      if (i == SIDE_L) begin
        sum = F_W'(ctxd_r.lv) + cs;
      end else begin
        sum = F_W'(ctxd_r.rv) - cs;
      end
      if (sum > F_W'(S_MAX)) begin
        face[i] = S_MAX;
        clip    = 1'b1;
      end else if (sum < F_W'(S_MIN)) begin
        face[i] = S_MIN;
        clip    = 1'b1;
      end else begin
        face[i] = sum[DW-1:0];
      end
    end
    out_nxt.left_face_value  = face[SIDE_L];
    out_nxt.right_face_value = face[SIDE_R];
    out_nxt.saturated        = clip;
  end

  always_ff @(posedge clk) begin
    if (en && vld_d_r) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- assertions ----------------
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready && vld_d_r))
    else $error("input held off without a parked result behind a full tail");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(vld_d_r))
    else $error("result appeared without a valid tail stage");

  a_mode_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(cfg_wr)) |-> $stable(limiter_mode_r))
    else $error("limiter mode changed without a config transfer");

endmodule

`default_nettype wire
